@@ hdl/lci_pkg.sv @@
// shared types and constants of the curve interpolation block
// request structs, status and function codes, arithmetic unit handshake
// depends on nothing
package lci_pkg;

    localparam int unsigned DATA_W = 24;
    localparam int unsigned FRAC_W = 16;
    localparam int unsigned QUO_W  = FRAC_W + 1;
    localparam int unsigned PROD_W = 2 * DATA_W;

    typedef logic [DATA_W-1:0] t_word;

    localparam logic [1:0] FUNC_CLEAR = 2'd0;
    localparam logic [1:0] FUNC_LOAD  = 2'd1;
    localparam logic [1:0] FUNC_QUERY = 2'd2;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;
    localparam logic [1:0] ST_SAT   = 2'd3;

    localparam logic [1:0] CFG_MIN_SPEED = 2'd0;
    localparam logic [1:0] CFG_MAX_SPEED = 2'd1;
    localparam logic [1:0] CFG_SENS      = 2'd2;

    localparam t_word MIN_SPEED_RST = 24'h000000;
    localparam t_word MAX_SPEED_RST = 24'hFFFFFF;
    localparam t_word SENS_RST      = 24'h010000;
    localparam t_word SAT_MAX       = 24'hFFFFFF;

    localparam logic [QUO_W-1:0] T_ONE = {1'b1, {FRAC_W{1'b0}}};

    typedef struct packed {
        logic [1:0] func;
        t_word      point_speed;
        t_word      point_mult;
        t_word      velocity;
    } t_in_item;

    typedef struct packed {
        t_word      result_mult;
        logic [1:0] status;
    } t_out_item;

    typedef struct packed {
        logic [1:0] index;
        t_word      data;
    } t_cfg_item;

    typedef struct packed {
        t_word speed;
        t_word mult;
    } t_point;

    typedef enum logic {
        ARITH_DIV = 1'b0,
        ARITH_MUL = 1'b1
    } t_arith_op;

    typedef struct packed {
        logic      start;
        t_arith_op op;
        t_word     a;
        t_word     b;
    } t_arith_req;

    typedef struct packed {
        logic              done;
        logic [QUO_W-1:0]  quo;
        logic [PROD_W-1:0] prod;
    } t_arith_rsp;

endpackage

@@ hdl/lci_stream_if.sv @@
// valid/ready channel with a payload of any packed type
// source and sink modports; depends on nothing
interface lci_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

@@ hdl/lut_accel_curve_interp.sv @@
// Pointer acceleration curve: a sorted table of (speed, multiplier) points held in one ram,
// evaluated by piecewise linear interpolation and scaled by the sensitivity register. One request
// is worked on at a time and a new one is taken while the previous result waits at the output.
// Clear, unknown functions and empty/full cases go straight to the done state; a load moves each
// larger point up by one entry and then writes the new point; a query reads the first and last
// points and, for a velocity between them, scans the table through the single ram read port and
// interpolates with the 17 step divider and the multiplier of the shared arithmetic unit.
// Depends on lci_pkg, lci_stream_if, lci_ram and lci_arith.
module lut_accel_curve_interp
    import lci_pkg::*;
#(
    parameter int unsigned MAX_POINTS = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    lci_stream_if.sink    i_in,
    lci_stream_if.source  o_out,
    lci_stream_if.sink    i_cfg
);
    localparam int unsigned AW = $clog2(MAX_POINTS);
    localparam int unsigned CW = $clog2(MAX_POINTS + 1);
    localparam logic [CW-1:0] MAX_COUNT = CW'(MAX_POINTS);

    typedef enum logic [10:0] {
        S_IDLE     = 11'b000_0000_0001,
        S_INS_CMP  = 11'b000_0000_0010,
        S_INS_PUT  = 11'b000_0000_0100,
        S_Q_FIRST  = 11'b000_0000_1000,
        S_Q_LAST   = 11'b000_0001_0000,
        S_Q_SCAN   = 11'b000_0010_0000,
        S_DIV      = 11'b000_0100_0000,
        S_MUL_T    = 11'b000_1000_0000,
        S_SCALE    = 11'b001_0000_0000,
        S_SCALE_WT = 11'b010_0000_0000,
        S_DONE     = 11'b100_0000_0000
    } t_state;

    t_state        r_state, n_state;
    logic [CW-1:0] r_count, n_count;
    logic [AW-1:0] r_k, n_k;
    logic [AW-1:0] r_j, n_j;
    t_point        r_new, n_new;
    t_word         r_v, n_v;
    t_point        r_prev, n_prev;
    t_point        r_cur, n_cur;
    t_word         r_mult, n_mult;
    t_word         r_res, n_res;
    logic [1:0]    r_stat, n_stat;
    t_word         r_min, r_max, r_sens;
    logic          r_out_valid;
    t_out_item     r_out;

    logic [AW-1:0] w_raddr, w_waddr;
    logic          w_we;
    t_point        w_wdata, w_rdata;
    t_arith_req    w_req;
    t_arith_rsp    w_rsp;
    t_word         w_vel_lo, w_vel;
    t_word         w_dm, w_delta, w_interp;
    logic          w_m_up;
    logic          w_out_load;

    lci_ram #(
        .WIDTH ($bits(t_point)),
        .DEPTH (MAX_POINTS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    lci_arith u_arith (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .o_rsp   (w_rsp)
    );

    // velocity clamp, upper bound wins
    assign w_vel_lo = (i_in.payload.velocity < r_min) ? r_min : i_in.payload.velocity;
    assign w_vel    = (w_vel_lo > r_max) ? r_max : w_vel_lo;

    assign w_m_up   = (r_cur.mult >= r_prev.mult);
    assign w_dm     = w_m_up ? (r_cur.mult - r_prev.mult) : (r_prev.mult - r_cur.mult);
    assign w_delta  = w_rsp.prod[FRAC_W +: DATA_W];
    assign w_interp = w_m_up ? (r_prev.mult + w_delta) : (r_prev.mult - w_delta);

    assign w_out_load = (r_state == S_DONE) && (!r_out_valid || o_out.ready);

    assign i_in.ready    = (r_state == S_IDLE);
    assign i_cfg.ready   = 1'b1;
    assign o_out.valid   = r_out_valid;
    assign o_out.payload = r_out;

    always_comb begin
        n_state = r_state;
        n_count = r_count;
        n_k     = r_k;
        n_j     = r_j;
        n_new   = r_new;
        n_v     = r_v;
        n_prev  = r_prev;
        n_cur   = r_cur;
        n_mult  = r_mult;
        n_res   = r_res;
        n_stat  = r_stat;
        w_raddr = '0;
        w_we    = 1'b0;
        w_waddr = r_k;
        w_wdata = r_new;
        w_req   = '{start: 1'b0, op: ARITH_MUL, a: '0, b: '0};
        case (r_state)
            S_IDLE: begin
                if (i_in.payload.func == FUNC_LOAD) begin
                    w_raddr = AW'(r_count - 1'b1);
                end
                if (i_in.valid) begin
                    n_new   = '{speed: i_in.payload.point_speed, mult: i_in.payload.point_mult};
                    n_v     = w_vel;
                    n_res   = '0;
                    n_stat  = ST_OK;
                    n_state = S_DONE;
                    case (i_in.payload.func)
                        FUNC_CLEAR: begin
                            n_count = '0;
                        end
                        FUNC_LOAD: begin
                            if (r_count == MAX_COUNT) begin
                                n_stat = ST_FULL;
                            end else begin
                                n_k     = AW'(r_count);
                                n_state = (r_count == '0) ? S_INS_PUT : S_INS_CMP;
                            end
                        end
                        FUNC_QUERY: begin
                            if (r_count == '0) begin
                                n_res  = r_sens;
                                n_stat = ST_EMPTY;
                            end else begin
                                n_state = S_Q_FIRST;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            // move larger speeds up by one, entry k-1 is on the read port
            S_INS_CMP: begin
                if (w_rdata.speed > r_new.speed) begin
                    w_we    = 1'b1;
                    w_waddr = r_k;
                    w_wdata = w_rdata;
                    w_raddr = r_k - 1'b1 - 1'b1;
                    n_k     = r_k - 1'b1;
                    if (r_k == AW'(1)) begin
                        n_state = S_INS_PUT;
                    end
                end else begin
                    n_state = S_INS_PUT;
                end
            end
            S_INS_PUT: begin
                w_we    = 1'b1;
                w_waddr = r_k;
                w_wdata = r_new;
                n_count = r_count + 1'b1;
                n_state = S_DONE;
            end
            S_Q_FIRST: begin
                n_prev = w_rdata;
                if (r_v <= w_rdata.speed) begin
                    n_mult  = w_rdata.mult;
                    n_state = S_SCALE;
                end else begin
                    w_raddr = AW'(r_count - 1'b1);
                    n_state = S_Q_LAST;
                end
            end
            S_Q_LAST: begin
                if (r_v >= w_rdata.speed) begin
                    n_mult  = w_rdata.mult;
                    n_state = S_SCALE;
                end else begin
                    w_raddr = AW'(1);
                    n_j     = AW'(1);
                    n_state = S_Q_SCAN;
                end
            end
            // first upper point at or above the velocity closes the interval
            S_Q_SCAN: begin
                w_raddr = r_j + 1'b1;
                if (w_rdata.speed >= r_v) begin
                    n_cur   = w_rdata;
                    w_req   = '{start: 1'b1, op: ARITH_DIV,
                                a: r_v - r_prev.speed, b: w_rdata.speed - r_prev.speed};
                    n_state = S_DIV;
                end else begin
                    n_prev = w_rdata;
                    n_j    = r_j + 1'b1;
                end
            end
            S_DIV: begin
                if (w_rsp.done) begin
                    w_req   = '{start: 1'b1, op: ARITH_MUL, a: DATA_W'(w_rsp.quo), b: w_dm};
                    n_state = S_MUL_T;
                end
            end
            S_MUL_T: begin
                if (w_rsp.done) begin
                    n_mult  = w_interp;
                    n_state = S_SCALE;
                end
            end
            S_SCALE: begin
                w_req   = '{start: 1'b1, op: ARITH_MUL, a: r_mult, b: r_sens};
                n_state = S_SCALE_WT;
            end
            S_SCALE_WT: begin
                if (w_rsp.done) begin
                    if (|w_rsp.prod[PROD_W-1:FRAC_W+DATA_W]) begin
                        n_res  = SAT_MAX;
                        n_stat = ST_SAT;
                    end else begin
                        n_res  = w_rsp.prod[FRAC_W +: DATA_W];
                        n_stat = ST_OK;
                    end
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (w_out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
        r_k    <= n_k;
        r_j    <= n_j;
        r_new  <= n_new;
        r_v    <= n_v;
        r_prev <= n_prev;
        r_cur  <= n_cur;
        r_mult <= n_mult;
        r_res  <= n_res;
        r_stat <= n_stat;
        if (w_out_load) begin
            r_out <= '{result_mult: r_res, status: r_stat};
        end
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min  <= MIN_SPEED_RST;
            r_max  <= MAX_SPEED_RST;
            r_sens <= SENS_RST;
        end else if (i_cfg.valid) begin
            case (i_cfg.payload.index)
                CFG_MIN_SPEED: r_min  <= i_cfg.payload.data;
                CFG_MAX_SPEED: r_max  <= i_cfg.payload.data;
                CFG_SENS:      r_sens <= i_cfg.payload.data;
                default: begin
                end
            endcase
        end
    end

`ifndef SYNTH
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= MAX_COUNT)
        else $error("point count above table size");

    a_full_keeps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready && i_in.payload.func == FUNC_LOAD && r_count == MAX_COUNT)
        |=> (r_count == $past(r_count)))
        else $error("load into full table changed point count");

    a_scan_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_Q_SCAN) |-> (CW'(r_j) < r_count))
        else $error("interval scan ran past last point");

    a_quo_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV && w_rsp.done) |-> (w_rsp.quo <= T_ONE))
        else $error("interpolation fraction above one");
`endif
endmodule

@@ hdl/lci_ram.sv @@
// generic single write port, single read port ram with registered read
// depends on nothing
module lci_ram #(
    parameter int unsigned WIDTH = 48,
    parameter int unsigned DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

@@ hdl/lci_arith.sv @@
// shared arithmetic unit: 17 step restoring divider and a registered 24x24 multiplier
// depends on lci_pkg
module lci_arith
    import lci_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_arith_req i_req,
    output t_arith_rsp o_rsp
);
    localparam int unsigned REM_W = DATA_W + 1;
    localparam int unsigned CNT_W = $clog2(QUO_W);
    localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(QUO_W - 1);

    logic              r_busy, n_busy;
    logic              r_done, n_done;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic [REM_W-1:0]  r_rem, n_rem;
    t_word             r_den, n_den;
    logic [QUO_W-1:0]  r_quo, n_quo;
    logic [PROD_W-1:0] r_prod, n_prod;
    logic [REM_W:0]    w_diff;
    logic              w_ge;

    assign w_diff = {1'b0, r_rem} - {2'b00, r_den};
    assign w_ge   = ~w_diff[REM_W];

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_den  = r_den;
        n_quo  = r_quo;
        n_prod = r_prod;
        if (i_req.start) begin
            if (i_req.op == ARITH_MUL) begin
                n_prod = i_req.a * i_req.b;
                n_done = 1'b1;
            end else begin
                n_busy = 1'b1;
                n_cnt  = '0;
                n_rem  = {1'b0, i_req.a};
                n_den  = i_req.b;
                n_quo  = '0;
            end
        end else if (r_busy) begin
            n_quo = {r_quo[QUO_W-2:0], w_ge};
            n_rem = w_ge ? {w_diff[DATA_W-1:0], 1'b0} : {r_rem[DATA_W-1:0], 1'b0};
            n_cnt = r_cnt + 1'b1;
            if (r_cnt == LAST_STEP) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_cnt  <= n_cnt;
        r_rem  <= n_rem;
        r_den  <= n_den;
        r_quo  <= n_quo;
        r_prod <= n_prod;
    end

    assign o_rsp = '{done: r_done, quo: r_quo, prod: r_prod};
endmodule
